// ----- hdl/mqbf_pkg.sv -----
// Package for the multi-queue byte FIFO: action and status codes, controller
// state type and the command bundle passed from controller to datapath.
// No dependencies.
package mqbf_pkg;

    localparam int ACTION_W = 2;
    localparam int QIDX_W   = 4;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 9;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 9;

    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TAKE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_QUEUE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT    = 2'd2;

    typedef enum logic [1:0] {
        CTRL_IDLE,
        CTRL_EXEC,
        CTRL_DELIVER
    } ctrl_state_t;

    typedef struct packed {
        logic latch;    // capture the accepted request
        logic execute;  // queue bookkeeping and store access
        logic deliver;  // load the output register
    } dp_cmd_t;

endpackage

// ----- hdl/mqbf_ctrl.sv -----
// Controller state machine of the multi-queue byte FIFO.
// Sequences capture, execution and delivery; owns both handshakes.
// Depends on mqbf_pkg.
module mqbf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output mqbf_pkg::dp_cmd_t cmd
);

    mqbf_pkg::ctrl_state_t state_reg, state_next;
    logic                  m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mqbf_pkg::CTRL_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // The output slot is free when empty or being emptied this cycle.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mqbf_pkg::CTRL_IDLE: begin
                if (s_valid) begin
                    state_next = mqbf_pkg::CTRL_EXEC;
                end
            end
            mqbf_pkg::CTRL_EXEC: begin
                state_next = mqbf_pkg::CTRL_DELIVER;
            end
            mqbf_pkg::CTRL_DELIVER: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = mqbf_pkg::CTRL_IDLE;
                end
            end
            default: begin
                state_next = mqbf_pkg::CTRL_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = (state_reg == mqbf_pkg::CTRL_IDLE);
        cmd.latch   = (state_reg == mqbf_pkg::CTRL_IDLE) && s_valid;
        cmd.execute = (state_reg == mqbf_pkg::CTRL_EXEC);
        cmd.deliver = (state_reg == mqbf_pkg::CTRL_DELIVER) && (!m_valid_reg || m_ready);
        if (cmd.deliver) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- hdl/mqbf_dp.sv -----
// Datapath of the multi-queue byte FIFO: request register, per-queue
// positions and counts, transfer tracking, shared byte store, output register.
// Depends on mqbf_pkg; driven by mqbf_ctrl commands.
module mqbf_dp #(
    parameter int QUEUES = 4,
    parameter int DEPTH  = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mqbf_pkg::dp_cmd_t                 cmd,
    input  logic [mqbf_pkg::ACTION_W-1:0]     s_action,
    input  logic [mqbf_pkg::QIDX_W-1:0]       s_queue_index,
    input  logic [mqbf_pkg::BYTE_W-1:0]       s_put_byte,
    input  logic                              s_transfer_first,
    input  logic [mqbf_pkg::LEN_W-1:0]        s_transfer_length,
    output logic [mqbf_pkg::BYTE_W-1:0]       m_taken_byte,
    output logic [mqbf_pkg::STATUS_W-1:0]     m_status,
    output logic [mqbf_pkg::FILL_W-1:0]       m_fill_count
);

    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int QSEL_W    = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int MEM_DEPTH = QUEUES * (2 ** PTR_W);
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int SUM_W     = ((CNT_W > mqbf_pkg::LEN_W) ? CNT_W : mqbf_pkg::LEN_W) + 1;
    localparam int QCMP_W    = ((QSEL_W > mqbf_pkg::QIDX_W) ? QSEL_W : mqbf_pkg::QIDX_W) + 1;

    // Captured request.
    logic [mqbf_pkg::ACTION_W-1:0] action_reg;
    logic [mqbf_pkg::QIDX_W-1:0]   qidx_reg;
    logic [mqbf_pkg::BYTE_W-1:0]   put_byte_reg;
    logic                          first_reg;
    logic [mqbf_pkg::LEN_W-1:0]    len_reg;

    // Queue bookkeeping.
    logic [PTR_W-1:0] rd_pos_reg [QUEUES];
    logic [PTR_W-1:0] wr_pos_reg [QUEUES];
    logic [CNT_W-1:0] count_reg  [QUEUES];
    logic             open_reg, open_next;
    logic             admitted_reg, admitted_next;
    logic [mqbf_pkg::LEN_W-1:0] left_reg, left_next;

    // Result staging and store.
    logic [mqbf_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [mqbf_pkg::FILL_W-1:0]   res_fill_reg, res_fill_next;
    logic                          res_take_reg, res_take_next;
    logic [mqbf_pkg::BYTE_W-1:0]   byte_store [MEM_DEPTH];
    logic [mqbf_pkg::BYTE_W-1:0]   rd_data_reg;
    logic [mqbf_pkg::BYTE_W-1:0]   taken_byte_reg;
    logic [mqbf_pkg::STATUS_W-1:0] status_reg;
    logic [mqbf_pkg::FILL_W-1:0]   fill_reg;

    // Combinational decision of the executing request.
    logic                          good;
    logic [QSEL_W-1:0]             qsel;
    logic [PTR_W-1:0]              rd_pos_cur, wr_pos_cur, rd_pos_new, wr_pos_new;
    logic [CNT_W-1:0]              cnt_cur, cnt_new;
    logic                          mem_we, mem_re;
    logic [ADDR_W-1:0]             mem_addr;

    function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            action_reg   <= s_action;
            qidx_reg     <= s_queue_index;
            put_byte_reg <= s_put_byte;
            first_reg    <= s_transfer_first;
            len_reg      <= s_transfer_length;
        end
    end

    assign good       = QCMP_W'(qidx_reg) < QCMP_W'(QUEUES);
    assign qsel       = good ? QSEL_W'(qidx_reg) : '0;
    assign rd_pos_cur = rd_pos_reg[qsel];
    assign wr_pos_cur = wr_pos_reg[qsel];
    assign cnt_cur    = count_reg[qsel];

    always_comb begin
        logic                       is_put;
        logic                       start;
        logic [mqbf_pkg::LEN_W-1:0] n;
        logic                       ok;
        logic                       move;
        logic [PTR_W-1:0]           pos;

        is_put          = (action_reg == mqbf_pkg::ACT_PUT);
        start           = first_reg || !open_reg;
        n               = first_reg ? len_reg : mqbf_pkg::LEN_W'(1);
        ok              = 1'b0;
        move            = 1'b0;
        pos             = '0;
        open_next       = open_reg;
        admitted_next   = admitted_reg;
        left_next       = left_reg;
        res_status_next = mqbf_pkg::ST_DONE;
        res_take_next   = 1'b0;
        rd_pos_new      = rd_pos_cur;
        wr_pos_new      = wr_pos_cur;
        cnt_new         = cnt_cur;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        if (action_reg == mqbf_pkg::ACT_CLEAR || action_reg == mqbf_pkg::ACT_QUERY) begin
            if (!good) begin
                res_status_next = mqbf_pkg::ST_BAD_QUEUE;
            end else if (action_reg == mqbf_pkg::ACT_CLEAR) begin
                rd_pos_new = '0;
                wr_pos_new = '0;
                cnt_new    = '0;
            end
        end else begin
            if (good) begin
                if (is_put) begin
                    ok = (SUM_W'(cnt_cur) + SUM_W'(n)) <= SUM_W'(DEPTH);
                end else begin
                    ok = SUM_W'(n) <= SUM_W'(cnt_cur);
                end
            end
            if (start) begin
                if (n == '0) begin
                    open_next     = 1'b0;
                    admitted_next = 1'b0;
                    left_next     = '0;
                    res_status_next = good ? mqbf_pkg::ST_DONE : mqbf_pkg::ST_BAD_QUEUE;
                end else begin
                    admitted_next = ok;
                    left_next     = n - 1'b1;
                    open_next     = (n != mqbf_pkg::LEN_W'(1));
                    move          = ok;
                    if (!ok) begin
                        res_status_next = good ? mqbf_pkg::ST_REJECT : mqbf_pkg::ST_BAD_QUEUE;
                    end
                end
            end else begin
                // Continuation of an open transfer follows the earlier verdict.
                move = admitted_reg;
                if (left_reg != '0) begin
                    left_next = left_reg - 1'b1;
                end
                open_next = (left_next != '0);
                if (!good) begin
                    res_status_next = mqbf_pkg::ST_BAD_QUEUE;
                end else if (!move) begin
                    res_status_next = mqbf_pkg::ST_REJECT;
                end
            end
            if (move && good) begin
                if (is_put) begin
                    if (cnt_cur >= CNT_W'(DEPTH)) begin
                        res_status_next = mqbf_pkg::ST_REJECT;
                    end else begin
                        mem_we     = 1'b1;
                        pos        = wr_pos_cur;
                        wr_pos_new = next_pos(wr_pos_cur);
                        cnt_new    = cnt_cur + 1'b1;
                    end
                end else begin
                    if (cnt_cur == '0) begin
                        res_status_next = mqbf_pkg::ST_REJECT;
                    end else begin
                        mem_re        = 1'b1;
                        res_take_next = 1'b1;
                        pos           = rd_pos_cur;
                        rd_pos_new    = next_pos(rd_pos_cur);
                        cnt_new       = cnt_cur - 1'b1;
                    end
                end
            end
        end
        res_fill_next = good ? mqbf_pkg::FILL_W'(cnt_new) : '0;
        mem_addr      = ADDR_W'({qsel, pos});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < QUEUES; i++) begin
                rd_pos_reg[i] <= '0;
                wr_pos_reg[i] <= '0;
                count_reg[i]  <= '0;
            end
            open_reg     <= 1'b0;
            admitted_reg <= 1'b0;
            left_reg     <= '0;
        end else if (cmd.execute) begin
            if (good) begin
                rd_pos_reg[qsel] <= rd_pos_new;
                wr_pos_reg[qsel] <= wr_pos_new;
                count_reg[qsel]  <= cnt_new;
            end
            open_reg     <= open_next;
            admitted_reg <= admitted_next;
            left_reg     <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            res_status_reg <= res_status_next;
            res_fill_reg   <= res_fill_next;
            res_take_reg   <= res_take_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute && mem_we) begin
            byte_store[mem_addr] <= put_byte_reg;
        end
        if (cmd.execute && mem_re) begin
            rd_data_reg <= byte_store[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.deliver) begin
            taken_byte_reg <= res_take_reg ? rd_data_reg : '0;
            status_reg     <= res_status_reg;
            fill_reg       <= res_fill_reg;
        end
    end

    assign m_taken_byte = taken_byte_reg;
    assign m_status     = status_reg;
    assign m_fill_count = fill_reg;

endmodule

// ----- hdl/multi_queue_byte_fifo.sv -----
// Multi-queue byte FIFO: QUEUES byte ring buffers of DEPTH bytes in one store.
// A request moves through capture, the queue read-modify-write with the
// registered store read, and the output register load; a new request is
// accepted only after the previous result is loaded into the output register.
// Reset clears positions, counts and transfer state; the store itself is
// not cleared.
module multi_queue_byte_fifo #(
    parameter int QUEUES = 4,
    parameter int DEPTH  = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mqbf_pkg::ACTION_W-1:0] s_action,
    input  logic [mqbf_pkg::QIDX_W-1:0]   s_queue_index,
    input  logic [mqbf_pkg::BYTE_W-1:0]   s_put_byte,
    input  logic                          s_transfer_first,
    input  logic [mqbf_pkg::LEN_W-1:0]    s_transfer_length,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mqbf_pkg::BYTE_W-1:0]   m_taken_byte,
    output logic [mqbf_pkg::STATUS_W-1:0] m_status,
    output logic [mqbf_pkg::FILL_W-1:0]   m_fill_count
);

    mqbf_pkg::dp_cmd_t cmd;

    mqbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    mqbf_dp #(
        .QUEUES (QUEUES),
        .DEPTH  (DEPTH)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .s_action          (s_action),
        .s_queue_index     (s_queue_index),
        .s_put_byte        (s_put_byte),
        .s_transfer_first  (s_transfer_first),
        .s_transfer_length (s_transfer_length),
        .m_taken_byte      (m_taken_byte),
        .m_status          (m_status),
        .m_fill_count      (m_fill_count)
    );

endmodule
